>>> sv/julia_escape_time_pixel_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Julia escape-time pixel checker
// Clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define JULIA_ESCAPE_TIME_PIXEL_ASSERT_SVH

// Same-cycle implication.
`define JETP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JETP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/jetp_pkg.sv
// ---------------------------------------------------------------------------
// jetp_pkg
// Types, constants and helpers shared by the Julia escape-time pixel block.
// ---------------------------------------------------------------------------
package jetp_pkg;

    localparam int FRAC_BITS = 26;
    localparam int DIV_STEPS = 8;
    localparam int NUM_CHANNELS = 3;

    // Configuration register indexes
    localparam logic [2:0] REG_C_REAL     = 3'd0;
    localparam logic [2:0] REG_C_IMAG     = 3'd1;
    localparam logic [2:0] REG_START_REAL = 3'd2;
    localparam logic [2:0] REG_START_IMAG = 3'd3;
    localparam logic [2:0] REG_STEP_REAL  = 3'd4;
    localparam logic [2:0] REG_STEP_IMAG  = 3'd5;
    localparam logic [2:0] REG_ITER_LIMIT = 3'd6;
    localparam logic [2:0] REG_GAINS      = 3'd7;

    // Color channel tags
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam logic [31:0] INSIDE_COLOR = 32'h0000_00FF;
    localparam logic [7:0]  ALPHA = 8'hFF;

    // 5.0 in Q(2*FRAC_BITS)
    localparam logic [63:0] ESC_THRESH = 64'd5 << (2 * FRAC_BITS);

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } jetp_in_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [10:0] step_count;
        logic        inside_res;
    } jetp_out_t;

    // One slot of the division chain
    typedef struct packed {
        logic        vld;
        logic [1:0]  tag;
        logic [33:0] rem;
        logic [33:0] dsh;
        logic [7:0]  quo;
    } jetp_div_t;

    function automatic logic [31:0] jetp_sat32(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            return 32'h7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

>>> sv/jetp_div_cell.sv
// ---------------------------------------------------------------------------
// jetp_div_cell
// One restoring-division step: subtract the shifted divisor when it fits.
// ---------------------------------------------------------------------------
module jetp_div_cell
    import jetp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  jetp_div_t cell_in,
    output jetp_div_t cell_out
);

    jetp_div_t out_reg;
    jetp_div_t out_next;
    logic      fits;

    always_comb begin
        fits = (cell_in.rem >= cell_in.dsh);
        out_next.vld = cell_in.vld;
        out_next.tag = cell_in.tag;
        out_next.rem = fits ? (cell_in.rem - cell_in.dsh) : cell_in.rem;
        out_next.dsh = cell_in.dsh >> 1;
        out_next.quo = {cell_in.quo[6:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.vld <= 1'b0;
        end else begin
            out_reg.vld <= out_next.vld;
        end
        out_reg.tag <= out_next.tag;
        out_reg.rem <= out_next.rem;
        out_reg.dsh <= out_next.dsh;
        out_reg.quo <= out_next.quo;
    end

    assign cell_out = out_reg;

endmodule

>>> sv/jetp_div_chain.sv
// ---------------------------------------------------------------------------
// jetp_div_chain
// Row of division cells, one quotient bit per cell, one slot per cycle.
// ---------------------------------------------------------------------------
module jetp_div_chain
    import jetp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  jetp_div_t chain_in,
    output jetp_div_t chain_out
);

    jetp_div_t links [DIV_STEPS+1];

    assign links[0] = chain_in;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
        jetp_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (links[i]),
            .cell_out (links[i+1])
        );
    end

    assign chain_out = links[DIV_STEPS];

endmodule

>>> sv/julia_escape_time_pixel.sv
// ---------------------------------------------------------------------------
// julia_escape_time_pixel
// Julia-set escape-time colorer for one pixel coordinate per transfer.
// ---------------------------------------------------------------------------
// Sequence from input transfer to result: map, seed, then per step a multiply
// and a test-and-update (k = step_count, plus the final test), then square,
// scale, the division chain and finish.
// Throughput: one pixel at a time; the squaring unit handles each step as a
// multiply, then test and update, and the next pixel is taken once the result
// is in the output register.
// Reset: synchronous active-low aresetn; configuration and control registers
// return to their defaults, datapath registers are not reset.
module julia_escape_time_pixel
    import jetp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  jetp_in_t    s_data,
    // color output
    output logic        m_valid,
    input  logic        m_ready,
    output jetp_out_t   m_data
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_MAP   = 9'b0_0000_0010,
        ST_SEED  = 9'b0_0000_0100,
        ST_MUL   = 9'b0_0000_1000,
        ST_TEST  = 9'b0_0001_0000,
        ST_SQR   = 9'b0_0010_0000,
        ST_SCALE = 9'b0_0100_0000,
        ST_DIV   = 9'b0_1000_0000,
        ST_FIN   = 9'b1_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // ---------------- configuration registers ----------------
    logic [31:0] c_real_reg, c_imag_reg;
    logic [31:0] start_real_reg, start_imag_reg;
    logic [31:0] step_real_reg, step_imag_reg;
    logic [9:0]  iter_limit_reg;
    logic [23:0] gains_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg     <= 32'hFCCC_CCCD;   // -53687091
            c_imag_reg     <= 32'd10468982;
            start_real_reg <= 32'hF800_0000;   // -2.0
            start_imag_reg <= 32'hF800_0000;
            step_real_reg  <= 32'd262144;
            step_imag_reg  <= 32'd262144;
            iter_limit_reg <= 10'd100;
            gains_reg      <= 24'hFF_FFFF;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_C_REAL:     c_real_reg     <= cfg_wdata;
                REG_C_IMAG:     c_imag_reg     <= cfg_wdata;
                REG_START_REAL: start_real_reg <= cfg_wdata;
                REG_START_IMAG: start_imag_reg <= cfg_wdata;
                REG_STEP_REAL:  step_real_reg  <= cfg_wdata;
                REG_STEP_IMAG:  step_imag_reg  <= cfg_wdata;
                REG_ITER_LIMIT: iter_limit_reg <= cfg_wdata[9:0];
                REG_GAINS:      gains_reg      <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    logic [9:0]         px_reg, py_reg;
    logic signed [42:0] prod_re_reg, prod_im_reg;   // column/row offset
    logic [31:0]        zr_reg, zi_reg;
    logic signed [63:0] rr_reg, ii_reg, ri_reg;     // squares and cross term
    logic [10:0]        k_reg;
    logic [12:0]        lim5_reg;                   // 5 * limit
    logic               inside_reg;
    logic [21:0]        ksq_reg;
    logic [19:0]        lsq_reg;
    logic [33:0]        num_reg [NUM_CHANNELS];     // 16 k^2 * gain
    logic [24:0]        den_reg;                    // 25 limit^2
    logic [1:0]         feed_reg;
    logic               div_done_reg;
    logic [7:0]         chan_reg [NUM_CHANNELS];

    // output register
    logic      m_valid_reg;
    jetp_out_t m_data_reg;

    // ---------------- iteration step ----------------
    // Take the registered products, test for escape or limit, and form the
    // next z with floor rescaling and saturation.
    logic               escaped, limit_hit;
    logic [63:0]        mag_sq;
    logic signed [63:0] diff, nr, ni;
    logic [12:0]        k_x4;

    always_comb begin
        mag_sq    = rr_reg + ii_reg;
        escaped   = (mag_sq >= ESC_THRESH);
        k_x4      = {k_reg, 2'b00};
        limit_hit = (k_x4 >= lim5_reg);
        diff      = rr_reg - ii_reg;
        nr = (diff >>> FRAC_BITS) + $signed({{32{c_real_reg[31]}}, c_real_reg});
        ni = (ri_reg >>> (FRAC_BITS - 1)) + $signed({{32{c_imag_reg[31]}}, c_imag_reg});
    end

    // ---------------- division chain feed ----------------
    jetp_div_t div_in, div_out;
    logic [33:0] feed_num;

    always_comb begin
        case (feed_reg)
            CH_RED:   feed_num = num_reg[0];
            CH_GREEN: feed_num = num_reg[1];
            CH_BLUE:  feed_num = num_reg[2];
            default:  feed_num = '0;
        endcase
        div_in.vld = (state_reg == ST_DIV) && (feed_reg != CH_NONE);
        div_in.tag = feed_reg;
        div_in.rem = feed_num;
        // divisor aligned to the top quotient bit
        div_in.dsh = {2'b00, den_reg, 7'b0};
        div_in.quo = '0;
    end

    jetp_div_chain u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .chain_in  (div_in),
        .chain_out (div_out)
    );

    // ---------------- control ----------------
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MAP;
            ST_MAP:   state_next = ST_SEED;
            ST_SEED:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_TEST;
            ST_TEST:  state_next = (escaped || limit_hit) ? ST_SQR : ST_MUL;
            ST_SQR:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (div_done_reg) state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            feed_reg     <= CH_RED;
            div_done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // drop the result once transferred, load a new one from FIN
            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // advance the channel feed, one channel per cycle
            if (state_reg == ST_SCALE) begin
                feed_reg <= CH_RED;
            end else if (state_reg == ST_DIV && feed_reg != CH_NONE) begin
                feed_reg <= feed_reg + 2'd1;
            end
            if (state_reg == ST_SCALE) begin
                div_done_reg <= 1'b0;
            end else if (div_out.vld && div_out.tag == CH_BLUE) begin
                div_done_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                px_reg   <= s_data.pixel_x;
                py_reg   <= s_data.pixel_y;
                k_reg    <= '0;
                lim5_reg <= {3'b000, iter_limit_reg} + {1'b0, iter_limit_reg, 2'b00};
            end
            ST_MAP: begin
                prod_re_reg <= $signed({1'b0, px_reg}) * $signed(step_real_reg);
                prod_im_reg <= $signed({1'b0, py_reg}) * $signed(step_imag_reg);
            end
            ST_SEED: begin
                zr_reg <= jetp_sat32({{21{prod_re_reg[42]}}, prod_re_reg}
                                     + {{32{start_real_reg[31]}}, start_real_reg});
                zi_reg <= jetp_sat32({{21{prod_im_reg[42]}}, prod_im_reg}
                                     + {{32{start_imag_reg[31]}}, start_imag_reg});
            end
            ST_MUL: begin
                rr_reg <= $signed(zr_reg) * $signed(zr_reg);
                ii_reg <= $signed(zi_reg) * $signed(zi_reg);
                ri_reg <= $signed(zr_reg) * $signed(zi_reg);
            end
            ST_TEST: begin
                inside_reg <= limit_hit;
                if (!escaped && !limit_hit) begin
                    zr_reg <= jetp_sat32(nr);
                    zi_reg <= jetp_sat32(ni);
                    k_reg  <= k_reg + 11'd1;
                end
            end
            ST_SQR: begin
                ksq_reg <= k_reg * k_reg;
                lsq_reg <= iter_limit_reg * iter_limit_reg;
            end
            ST_SCALE: begin
                num_reg[0] <= {ksq_reg, 4'b0000} * gains_reg[23:16];
                num_reg[1] <= {ksq_reg, 4'b0000} * gains_reg[15:8];
                num_reg[2] <= {ksq_reg, 4'b0000} * gains_reg[7:0];
                den_reg    <= {5'b00000, lsq_reg} * 25'd25;
            end
            default: ;
        endcase
        // collect quotients as they leave the chain
        if (div_out.vld && div_out.tag != CH_NONE) begin
            chan_reg[div_out.tag] <= div_out.quo;
        end
        if (state_reg == ST_FIN && out_free) begin
            m_data_reg.pixel_color <= inside_reg ? INSIDE_COLOR
                                    : {chan_reg[0], chan_reg[1], chan_reg[2], ALPHA};
            m_data_reg.step_count  <= k_reg;
            m_data_reg.inside_res  <= inside_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> sv/jetp_checker.sv
// ---------------------------------------------------------------------------
// jetp_checker
// Port-level assertions for the Julia escape-time pixel block.
// ---------------------------------------------------------------------------
`include "julia_escape_time_pixel_assert.svh"

module jetp_checker
    import jetp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input jetp_out_t m_data
);

    `JETP_ASSERT_NEXT(a_one_pixel, s_valid && s_ready, !s_ready, "pixel taken while busy")
    `JETP_ASSERT_NOW(a_inside_color, m_valid && m_data.inside_res, m_data.pixel_color == INSIDE_COLOR, "inside pixel color wrong")
    `JETP_ASSERT_NOW(a_alpha, m_valid, m_data.pixel_color[7:0] == ALPHA, "alpha not opaque")
    `JETP_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped before transfer")

endmodule

bind julia_escape_time_pixel jetp_checker u_jetp_checker (.*);
